FILE: hdl/pn2d_pkg.sv
// Shared types and constants for the 2D gradient noise pixel unit.
// No dependencies; every other file in hdl/ imports this package.
package pn2d_pkg;

    // Field widths
    localparam int COORD_W = 12;
    localparam int DIM_W   = 13;
    localparam int SCALE_W = 16;
    localparam int NOISE_W = 19;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;

    // Fixed-point layout of the lattice position
    localparam int FRAC_W       = 16;
    localparam int ONE_Q16      = 65536;
    localparam int POS_SHIFT    = 24;
    localparam int LATTICE_SIZE = 256;
    localparam int CELL_W       = $clog2(LATTICE_SIZE);
    localparam int QUO_W        = CELL_W + FRAC_W;
    localparam int DIV_STEPS    = COORD_W + POS_SHIFT;

    // Largest map dimension honored when flagging the final pixel
    localparam int MAX_DIMENSION = 4096;

    // Fade polynomial coefficients
    localparam int FADE_K6      = 6;
    localparam int FADE_K15     = 15;
    localparam int FADE_K10_Q16 = 10 * ONE_Q16;
    localparam int FADE_W       = FRAC_W + 1;

    // Permutation multiplier
    localparam logic [CELL_W-1:0] PERM_MUL = CELL_W'(17);

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NOISE_SCALE = 2'd2;

    // Reset values of the configuration registers
    localparam logic [DIM_W-1:0]   RST_MAP_WIDTH   = 13'd256;
    localparam logic [DIM_W-1:0]   RST_MAP_HEIGHT  = 13'd256;
    localparam logic [SCALE_W-1:0] RST_NOISE_SCALE = 16'd256;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_BAD_DIMS  = 2'd1,
        STATUS_BAD_SCALE = 2'd2
    } status_t;

    // Control sideband that travels alongside each word
    typedef struct packed {
        logic    valid;
        status_t status;
        logic    last;
    } side_t;

    // Lattice permutation: (17 * i) mod LATTICE_SIZE
    function automatic logic [CELL_W-1:0] perm(input logic [CELL_W-1:0] i);
        return PERM_MUL * i;
    endfunction

endpackage

FILE: hdl/pn2d_divider.sv
// Pipelined restoring divider: (coord << POS_SHIFT) / scale, one quotient bit per stage.
// Depends on pn2d_pkg; instantiated twice by perlin_noise_2d_pixel_unit.
module pn2d_divider (
    input  logic                         clk,
    input  logic [pn2d_pkg::COORD_W-1:0] coord,
    input  logic [pn2d_pkg::SCALE_W-1:0] scale,
    output logic [pn2d_pkg::QUO_W-1:0]   quotient
);
    import pn2d_pkg::*;

    logic [SCALE_W-1:0] rem_reg [DIV_STEPS-1];
    logic [QUO_W-1:0]   quo_reg [DIV_STEPS];
    logic [COORD_W-1:0] crd_reg [COORD_W-1];

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic [SCALE_W-1:0] rem_in;
        logic [QUO_W-1:0]   quo_in;
        logic               dbit;
        logic [SCALE_W:0]   shifted;
        logic [SCALE_W:0]   diff;
        logic               ge;

        // Partial remainder and quotient from the previous stage
        if (k == 0) begin : g_first
            assign rem_in = '0;
            assign quo_in = '0;
        end
        else begin : g_next
            assign rem_in = rem_reg[k-1];
            assign quo_in = quo_reg[k-1];
        end

        // Dividend bit: coordinate bits first, then the zeros of the shift
        if (k == 0) begin : g_bit_first
            assign dbit = coord[COORD_W-1];
        end
        else if (k < COORD_W) begin : g_bit_coord
            assign dbit = crd_reg[k-1][COORD_W-1-k];
        end
        else begin : g_bit_zero
            assign dbit = 1'b0;
        end

        // Trial subtraction
        assign shifted = {rem_in, dbit};
        assign diff    = shifted - {1'b0, scale};
        assign ge      = (shifted >= {1'b0, scale});

        always_ff @(posedge clk)
        begin
            quo_reg[k] <= {quo_in[QUO_W-2:0], ge};
        end

        if (k < DIV_STEPS - 1) begin : g_rem
            always_ff @(posedge clk)
            begin
                rem_reg[k] <= ge ? diff[SCALE_W-1:0] : shifted[SCALE_W-1:0];
            end
        end

        // Carry the coordinate while its bits are still needed
        if (k == 0) begin : g_crd_first
            always_ff @(posedge clk)
            begin
                crd_reg[k] <= coord;
            end
        end
        else if (k < COORD_W - 1) begin : g_crd_next
            always_ff @(posedge clk)
            begin
                crd_reg[k] <= crd_reg[k-1];
            end
        end
    end

    assign quotient = quo_reg[DIV_STEPS-1];

endmodule

FILE: hdl/pn2d_fade.sv
// Three-stage pipeline for the quintic fade 6t^5 - 15t^4 + 10t^3 in Q.16.
// Depends on pn2d_pkg; instantiated twice by perlin_noise_2d_pixel_unit.
module pn2d_fade (
    input  logic                        clk,
    input  logic [pn2d_pkg::FRAC_W-1:0] t,
    output logic [pn2d_pkg::FADE_W-1:0] fade
);
    import pn2d_pkg::*;

    localparam int SQ_W  = 2 * FRAC_W;
    localparam int CUB_W = 3 * FRAC_W;
    localparam int SIX_W = SQ_W + 3;
    localparam int QH_W  = 21;
    localparam int QV_W  = 20;
    localparam int PR_W  = SQ_W + QV_W;

    logic [FRAC_W-1:0] t_reg;
    logic [SQ_W-1:0]   t2_reg;
    logic [SQ_W-1:0]   t3_reg;
    logic [QV_W-1:0]   qh_reg;
    logic [FADE_W-1:0] fade_reg;

    logic [CUB_W-1:0]  t3_full;
    logic [SIX_W-1:0]  six_t2;
    logic [QH_W-1:0]   qh_next;
    logic [PR_W-1:0]   prod;

    // Stage 1: square
    always_ff @(posedge clk)
    begin
        t_reg  <= t;
        t2_reg <= SQ_W'(t) * SQ_W'(t);
    end

    // Stage 2: cube scaled down, and the quadratic factor scaled down
    always_comb
    begin
        t3_full = CUB_W'(t2_reg) * CUB_W'(t_reg);
        six_t2  = SIX_W'(t2_reg) * SIX_W'(FADE_K6);
        qh_next = QH_W'(six_t2 >> FRAC_W) + QH_W'(FADE_K10_Q16)
                  - QH_W'(t_reg) * QH_W'(FADE_K15);
    end

    always_ff @(posedge clk)
    begin
        t3_reg <= t3_full[CUB_W-1:FRAC_W];
        qh_reg <= qh_next[QV_W-1:0];
    end

    // Stage 3: final product, keep the Q.16 result
    assign prod = PR_W'(t3_reg) * PR_W'(qh_reg);

    always_ff @(posedge clk)
    begin
        fade_reg <= prod[SQ_W+FADE_W-1:SQ_W];
    end

    assign fade = fade_reg;

endmodule

FILE: hdl/perlin_noise_2d_pixel_unit.sv
// Top level of the 2D gradient noise pixel unit: configuration registers,
// hashing, gradients and bilinear blend. Depends on pn2d_pkg, pn2d_divider, pn2d_fade.
//
// The unit takes one pixel word per clock and returns one result word per pixel,
// in order. The pipeline is made up of the two coordinate dividers, each a
// 36-stage restoring divider that resolves one quotient bit per stage, followed
// by nine stages of fade, gradient and blend arithmetic. busy is always low.
// done pulses for exactly one cycle with each result word and the receiver
// cannot stall: it must capture noise_value, status and last_pixel in that
// cycle. Configuration writes take effect at once and must only be made while
// no pixel is in flight.
module perlin_noise_2d_pixel_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [pn2d_pkg::COORD_W-1:0]          x_pixel,
    input  logic [pn2d_pkg::COORD_W-1:0]          y_pixel,
    output logic                                  done,
    output logic signed [pn2d_pkg::NOISE_W-1:0]   noise_value,
    output logic [1:0]                            status,
    output logic                                  last_pixel,
    input  logic                                  cfg_we,
    input  logic [pn2d_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [pn2d_pkg::CFG_W-1:0]            cfg_wdata
);
    import pn2d_pkg::*;

    localparam int OFS_W   = FRAC_W + 2;
    localparam int GRAD_W  = 20;
    localparam int DIFF_W  = 21;
    localparam int LERP_W  = 21;
    localparam int PROD_W  = OFS_W + DIFF_W;
    localparam int LATENCY = DIV_STEPS + 9;

    // Corner gradient: +/-u +/-2v, u and v swapped for the upper two codes
    function automatic logic signed [GRAD_W-1:0] grad(
        input logic [1:0]              h,
        input logic signed [OFS_W-1:0] x,
        input logic signed [OFS_W-1:0] y
    );
        logic signed [GRAD_W-1:0] u;
        logic signed [GRAD_W-1:0] v;
        logic signed [GRAD_W-1:0] su;
        logic signed [GRAD_W-1:0] sv;
        u  = h[1] ? GRAD_W'(y) : GRAD_W'(x);
        v  = h[1] ? GRAD_W'(x) : GRAD_W'(y);
        su = h[0] ? -u : u;
        sv = h[1] ? -(v <<< 1) : (v <<< 1);
        return su + sv;
    endfunction

    logic [DIM_W-1:0]   map_width_reg;
    logic [DIM_W-1:0]   map_height_reg;
    logic [SCALE_W-1:0] noise_scale_reg;

    side_t              side_reg [LATENCY];
    side_t              side_next;
    logic [DIM_W-1:0]   w_sat;
    logic [DIM_W-1:0]   h_sat;

    logic [QUO_W-1:0]   quo_x;
    logic [QUO_W-1:0]   quo_y;
    logic [FADE_W-1:0]  fade_u;
    logic [FADE_W-1:0]  fade_v;

    logic [CELL_W-1:0]  cx;
    logic [CELL_W-1:0]  cy;
    logic [CELL_W-1:0]  hash_a;
    logic [CELL_W-1:0]  hash_b;
    logic [CELL_W-1:0]  p00;
    logic [CELL_W-1:0]  p10;
    logic [CELL_W-1:0]  p01;
    logic [CELL_W-1:0]  p11;
    logic [1:0]         hash_reg [4];
    logic [FRAC_W-1:0]  fx_reg;
    logic [FRAC_W-1:0]  fy_reg;

    logic signed [OFS_W-1:0]  x0;
    logic signed [OFS_W-1:0]  x1;
    logic signed [OFS_W-1:0]  y0;
    logic signed [OFS_W-1:0]  y1;
    logic signed [GRAD_W-1:0] g_reg [4];

    logic signed [DIFF_W-1:0] d0_reg;
    logic signed [DIFF_W-1:0] d1_reg;
    logic signed [GRAD_W-1:0] g00_h3_reg;
    logic signed [GRAD_W-1:0] g01_h3_reg;

    logic signed [OFS_W-1:0]  u_s;
    logic signed [PROD_W-1:0] m0_reg;
    logic signed [PROD_W-1:0] m1_reg;
    logic signed [GRAD_W-1:0] g00_b1_reg;
    logic signed [GRAD_W-1:0] g01_b1_reg;
    logic [FADE_W-1:0]        v_b1_reg;

    logic signed [PROD_W-1:0] l0_sum;
    logic signed [PROD_W-1:0] l1_sum;
    logic signed [LERP_W-1:0] l0_reg;
    logic signed [LERP_W-1:0] l1_reg;
    logic [FADE_W-1:0]        v_b2_reg;

    logic signed [LERP_W-1:0] d2_reg;
    logic signed [LERP_W-1:0] l0_b3_reg;
    logic [FADE_W-1:0]        v_b3_reg;

    logic signed [OFS_W-1:0]  v_s;
    logic signed [PROD_W-1:0] m2_reg;
    logic signed [LERP_W-1:0] l0_b4_reg;

    logic signed [PROD_W-1:0] res_sum;
    logic signed [LERP_W-1:0] res_reg;
    logic signed [LERP_W-1:0] biased;
    logic signed [LERP_W-1:0] val_next;
    logic signed [NOISE_W-1:0] val_reg;

    // The pipeline never refuses a word
    assign busy = 1'b0;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_width_reg   <= RST_MAP_WIDTH;
            map_height_reg  <= RST_MAP_HEIGHT;
            noise_scale_reg <= RST_NOISE_SCALE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MAP_WIDTH:   map_width_reg   <= cfg_wdata[DIM_W-1:0];
                REG_MAP_HEIGHT:  map_height_reg  <= cfg_wdata[DIM_W-1:0];
                REG_NOISE_SCALE: noise_scale_reg <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    // Entry checks: status and end-of-map flag
    always_comb
    begin
        w_sat = (map_width_reg > DIM_W'(MAX_DIMENSION)) ? DIM_W'(MAX_DIMENSION)
                                                         : map_width_reg;
        h_sat = (map_height_reg > DIM_W'(MAX_DIMENSION)) ? DIM_W'(MAX_DIMENSION)
                                                          : map_height_reg;
        side_next.valid = start && !busy;
        side_next.last  = 1'b0;
        if (map_width_reg == '0 || map_height_reg == '0)
        begin
            side_next.status = STATUS_BAD_DIMS;
        end
        else if (noise_scale_reg == '0)
        begin
            side_next.status = STATUS_BAD_SCALE;
        end
        else
        begin
            side_next.status = STATUS_OK;
            side_next.last   = (DIM_W'(x_pixel) + DIM_W'(1) == w_sat) &&
                               (DIM_W'(y_pixel) + DIM_W'(1) == h_sat);
        end
    end

    // Sideband pipeline, aligned with the datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LATENCY; i++)
            begin
                side_reg[i] <= '0;
            end
        end
        else
        begin
            side_reg[0] <= side_next;
            for (int i = 1; i < LATENCY; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // Lattice positions
    pn2d_divider u_div_x (
        .clk      (clk),
        .coord    (x_pixel),
        .scale    (noise_scale_reg),
        .quotient (quo_x)
    );

    pn2d_divider u_div_y (
        .clk      (clk),
        .coord    (y_pixel),
        .scale    (noise_scale_reg),
        .quotient (quo_y)
    );

    // Fade curves of the fractional offsets
    pn2d_fade u_fade_x (
        .clk  (clk),
        .t    (quo_x[FRAC_W-1:0]),
        .fade (fade_u)
    );

    pn2d_fade u_fade_y (
        .clk  (clk),
        .t    (quo_y[FRAC_W-1:0]),
        .fade (fade_v)
    );

    // Stage H1: corner hashes
    always_comb
    begin
        cx     = quo_x[QUO_W-1:FRAC_W];
        cy     = quo_y[QUO_W-1:FRAC_W];
        hash_a = perm(cx) + cy;
        hash_b = perm(cx + CELL_W'(1)) + cy;
        p00    = perm(hash_a);
        p10    = perm(hash_b);
        p01    = perm(hash_a + CELL_W'(1));
        p11    = perm(hash_b + CELL_W'(1));
    end

    always_ff @(posedge clk)
    begin
        hash_reg[0] <= p00[1:0];
        hash_reg[1] <= p10[1:0];
        hash_reg[2] <= p01[1:0];
        hash_reg[3] <= p11[1:0];
        fx_reg      <= quo_x[FRAC_W-1:0];
        fy_reg      <= quo_y[FRAC_W-1:0];
    end

    // Stage H2: corner gradients
    always_comb
    begin
        x0 = $signed({2'b00, fx_reg});
        y0 = $signed({2'b00, fy_reg});
        x1 = x0 - OFS_W'(ONE_Q16);
        y1 = y0 - OFS_W'(ONE_Q16);
    end

    always_ff @(posedge clk)
    begin
        g_reg[0] <= grad(hash_reg[0], x0, y0);
        g_reg[1] <= grad(hash_reg[1], x1, y0);
        g_reg[2] <= grad(hash_reg[2], x0, y1);
        g_reg[3] <= grad(hash_reg[3], x1, y1);
    end

    // Stage H3: differences along x
    always_ff @(posedge clk)
    begin
        d0_reg     <= DIFF_W'(g_reg[1]) - DIFF_W'(g_reg[0]);
        d1_reg     <= DIFF_W'(g_reg[3]) - DIFF_W'(g_reg[2]);
        g00_h3_reg <= g_reg[0];
        g01_h3_reg <= g_reg[2];
    end

    // Stage B1: weight the x differences by the fade of x
    assign u_s = $signed({1'b0, fade_u});

    always_ff @(posedge clk)
    begin
        m0_reg     <= PROD_W'(u_s) * PROD_W'(d0_reg);
        m1_reg     <= PROD_W'(u_s) * PROD_W'(d1_reg);
        g00_b1_reg <= g00_h3_reg;
        g01_b1_reg <= g01_h3_reg;
        v_b1_reg   <= fade_v;
    end

    // Stage B2: the two x blends, floor of the scaled product
    assign l0_sum = PROD_W'(g00_b1_reg) + (m0_reg >>> FRAC_W);
    assign l1_sum = PROD_W'(g01_b1_reg) + (m1_reg >>> FRAC_W);

    always_ff @(posedge clk)
    begin
        l0_reg   <= l0_sum[LERP_W-1:0];
        l1_reg   <= l1_sum[LERP_W-1:0];
        v_b2_reg <= v_b1_reg;
    end

    // Stage B3: difference along y
    always_ff @(posedge clk)
    begin
        d2_reg    <= l1_reg - l0_reg;
        l0_b3_reg <= l0_reg;
        v_b3_reg  <= v_b2_reg;
    end

    // Stage B4: weight by the fade of y
    assign v_s = $signed({1'b0, v_b3_reg});

    always_ff @(posedge clk)
    begin
        m2_reg    <= PROD_W'(v_s) * PROD_W'(d2_reg);
        l0_b4_reg <= l0_b3_reg;
    end

    // Stage B5: y blend
    assign res_sum = PROD_W'(l0_b4_reg) + (m2_reg >>> FRAC_W);

    always_ff @(posedge clk)
    begin
        res_reg <= res_sum[LERP_W-1:0];
    end

    // Stage B6: map to (res + 1) / 2, rounding toward minus infinity
    always_comb
    begin
        biased   = res_reg + LERP_W'(ONE_Q16);
        val_next = biased >>> 1;
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next[NOISE_W-1:0];
    end

    // Result word
    assign done        = side_reg[LATENCY-1].valid;
    assign status      = side_reg[LATENCY-1].status;
    assign last_pixel  = side_reg[LATENCY-1].last;
    assign noise_value = (side_reg[LATENCY-1].status == STATUS_OK) ? val_reg : '0;

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for perlin_noise_2d_pixel_unit: drives pixel words and
// register writes, predicts every result word and checks it. Depends on pn2d_pkg
// and the RTL of the unit; reads no files.
module testbench;

    import pn2d_pkg::*;

    localparam int WATCHDOG_LIMIT = 500;
    localparam int DRAIN_CYCLES   = 60;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 235;

    // Index one past the register list; writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef enum logic {
        ENTRY_PIXEL,
        ENTRY_WRITE
    } entry_kind_t;

    // One pending stimulus step: a pixel word or a register write.
    typedef struct packed {
        entry_kind_t          kind;
        logic [COORD_W-1:0]   x;
        logic [COORD_W-1:0]   y;
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_W-1:0]     data;
        logic [2:0]           gap;
    } stim_entry_t;

    // One result word as the unit should return it.
    typedef struct packed {
        logic signed [NOISE_W-1:0] noise;
        status_t                   status;
        logic                      last;
    } noise_word_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    logic [COORD_W-1:0]         x_pixel = '0;
    logic [COORD_W-1:0]         y_pixel = '0;
    logic                       done;
    logic signed [NOISE_W-1:0]  noise_value;
    logic [1:0]                 status;
    logic                       last_pixel;
    logic                       cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [CFG_W-1:0]           cfg_wdata = '0;

    stim_entry_t pending_items[$];
    noise_word_t expected_words[$];

    // Copy of the configuration registers as the unit should hold them.
    logic [DIM_W-1:0]   cur_width  = RST_MAP_WIDTH;
    logic [DIM_W-1:0]   cur_height = RST_MAP_HEIGHT;
    logic [SCALE_W-1:0] cur_scale  = RST_NOISE_SCALE;

    int pixels_sent    = 0;
    int words_checked  = 0;
    int writes_made    = 0;
    int error_words    = 0;
    int final_flags    = 0;
    int mismatch_count = 0;
    int idle_left      = 0;
    bit gap_loaded     = 1'b0;

    perlin_noise_2d_pixel_unit DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .x_pixel     (x_pixel),
        .y_pixel     (y_pixel),
        .done        (done),
        .noise_value (noise_value),
        .status      (status),
        .last_pixel  (last_pixel),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Lattice hash: multiply by 17 and wrap to the lattice.
    function automatic logic [7:0] lattice_hash(input logic [7:0] i);
        return 8'(17 * i);
    endfunction

    // Quintic fade 6t^5 - 15t^4 + 10t^3 on a Q.16 fraction.
    function automatic longint fade_curve(input longint unsigned t);
        longint unsigned poly;
        longint unsigned cube;
        poly = 6 * t * t + 10 * (64'd1 << 32) - 15 * 64'd65536 * t;
        cube = (t * t * t) >> 16;
        return longint'((cube * (poly >> 16)) >> 32);
    endfunction

    // Corner gradient: the low two hash bits pick swap and signs.
    function automatic longint corner_grad(input logic [7:0] hash, input longint dx,
                                           input longint dy);
        longint u;
        longint v;
        u = hash[1] ? dy : dx;
        v = hash[1] ? dx : dy;
        return (hash[0] ? -u : u) + (hash[1] ? -2 * v : 2 * v);
    endfunction

    // Linear blend with the product floored to Q.16.
    function automatic longint lerp_q16(input longint t, input longint a, input longint b);
        return a + ((t * (b - a)) >>> 16);
    endfunction

    // Expected result word for one pixel under the current register copy.
    function automatic noise_word_t predict_noise(input logic [COORD_W-1:0] xp,
                                                  input logic [COORD_W-1:0] yp);
        noise_word_t     w;
        longint unsigned px;
        longint unsigned py;
        longint unsigned wd;
        longint unsigned ht;
        logic [7:0]      cx;
        logic [7:0]      cy;
        logic [7:0]      ha;
        logic [7:0]      hb;
        longint          fx;
        longint          fy;
        longint          fu;
        longint          fv;
        longint          g00;
        longint          g10;
        longint          g01;
        longint          g11;
        longint          res;
        w.noise  = '0;
        w.status = STATUS_OK;
        w.last   = 1'b0;
        // Dimension errors take priority over a zero scale.
        if (cur_width == 0 || cur_height == 0)
        begin
            w.status = STATUS_BAD_DIMS;
            return w;
        end
        if (cur_scale == 0)
        begin
            w.status = STATUS_BAD_SCALE;
            return w;
        end
        wd = (cur_width > MAX_DIMENSION) ? MAX_DIMENSION : cur_width;
        ht = (cur_height > MAX_DIMENSION) ? MAX_DIMENSION : cur_height;

        // Lattice position with 16 fraction bits.
        px = (longint'(xp) << POS_SHIFT) / longint'(cur_scale);
        py = (longint'(yp) << POS_SHIFT) / longint'(cur_scale);
        cx = px[23:16];
        cy = py[23:16];
        fx = longint'(px & 64'hFFFF);
        fy = longint'(py & 64'hFFFF);
        fu = fade_curve(fx);
        fv = fade_curve(fy);

        // Hash the four corners and blend their gradients.
        ha  = lattice_hash(cx) + cy;
        hb  = lattice_hash(8'(cx + 8'd1)) + cy;
        g00 = corner_grad(lattice_hash(ha), fx, fy);
        g10 = corner_grad(lattice_hash(hb), fx - ONE_Q16, fy);
        g01 = corner_grad(lattice_hash(8'(ha + 8'd1)), fx, fy - ONE_Q16);
        g11 = corner_grad(lattice_hash(8'(hb + 8'd1)), fx - ONE_Q16, fy - ONE_Q16);
        res = lerp_q16(fv, lerp_q16(fu, g00, g10), lerp_q16(fu, g01, g11));

        w.noise = NOISE_W'((res + ONE_Q16) >>> 1);
        w.last  = (longint'(xp) + 1 == wd) && (longint'(yp) + 1 == ht);
        return w;
    endfunction

    // Mirror a register write into the local copy.
    function automatic void apply_write(input logic [CFG_IDX_W-1:0] index,
                                        input logic [CFG_W-1:0] data);
        case (index)
            REG_MAP_WIDTH:   cur_width  = data[DIM_W-1:0];
            REG_MAP_HEIGHT:  cur_height = data[DIM_W-1:0];
            REG_NOISE_SCALE: cur_scale  = data[SCALE_W-1:0];
            default:         ;
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("ERROR t=%0t word %0d: %s", $time, words_checked, what);
    endtask

    task automatic queue_pixel(input int x, input int y, input int gap);
        stim_entry_t e;
        e       = '0;
        e.kind  = ENTRY_PIXEL;
        e.x     = COORD_W'(x);
        e.y     = COORD_W'(y);
        e.gap   = 3'(gap);
        pending_items = {pending_items, e};
    endtask

    task automatic queue_write(input logic [CFG_IDX_W-1:0] index, input int data);
        stim_entry_t e;
        e       = '0;
        e.kind  = ENTRY_WRITE;
        e.index = index;
        e.data  = CFG_W'(data);
        pending_items = {pending_items, e};
    endtask

    function automatic int pick_gap(input bit bursty);
        if (bursty && $urandom_range(0, 3) == 0)
            return $urandom_range(1, 6);
        return 0;
    endfunction

    // Driver: one word per accepted start; register writes wait for an empty pipeline.
    always @(posedge clk)
    begin : drive_stim
        stim_entry_t head;
        logic        drive_start;
        logic        drive_we;
        if (rst_n)
        begin
            drive_start = 1'b0;
            drive_we    = 1'b0;
            if (start && !busy)
            begin
                expected_words = {expected_words, predict_noise(x_pixel, y_pixel)};
                void'(pending_items.pop_front());
                pixels_sent++;
                gap_loaded = 1'b0;
            end
            if (start && busy)
            begin
                drive_start = 1'b1;
            end
            else if (pending_items.size() != 0)
            begin
                head = pending_items[0];
                if (head.kind == ENTRY_WRITE)
                begin
                    if (pixels_sent == words_checked)
                    begin
                        drive_we = 1'b1;
                        cfg_index <= head.index;
                        cfg_wdata <= head.data;
                        apply_write(head.index, head.data);
                        void'(pending_items.pop_front());
                        writes_made++;
                    end
                end
                else
                begin
                    if (!gap_loaded)
                    begin
                        idle_left  = head.gap;
                        gap_loaded = 1'b1;
                    end
                    if (idle_left > 0)
                    begin
                        idle_left--;
                    end
                    else
                    begin
                        drive_start = 1'b1;
                        x_pixel <= head.x;
                        y_pixel <= head.y;
                    end
                end
            end
            start  <= drive_start;
            cfg_we <= drive_we;
        end
    end

    // Monitor: each strobed result word is checked against the oldest prediction.
    always @(posedge clk)
    begin : check_words
        noise_word_t want;
        if (rst_n && done)
        begin
            words_checked <= words_checked + 1;
            if (expected_words.size() == 0)
            begin
                report_mismatch($sformatf("unexpected word noise=%0d status=%0d last=%0b",
                                          noise_value, status, last_pixel));
            end
            else
            begin
                want = expected_words.pop_front();
                if (want.status != STATUS_OK)
                    error_words++;
                if (want.last)
                    final_flags++;
                if (noise_value !== want.noise)
                    report_mismatch($sformatf("noise_value %0d, expected %0d",
                                              noise_value, want.noise));
                if (status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              status, want.status));
                if (last_pixel !== want.last)
                    report_mismatch($sformatf("last_pixel %0b, expected %0b",
                                              last_pixel, want.last));
            end
        end
    end

    // Watchdog: stop the run when nothing moves for too long.
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (start && !busy) || done || cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("perlin_noise_2d_pixel_unit: mismatch");
        $finish;
    end

    // Stimulus plan and end of run.
    initial
    begin : stimulus
        logic [DIM_W-1:0]   w;
        logic [DIM_W-1:0]   h;
        logic [SCALE_W-1:0] s;
        int                 wl;
        int                 hl;
        int                 sel;
        bit                 bursty;

        // Reset settings: whole-cell steps, map corners, outside the map.
        queue_pixel(0, 0, 0);
        queue_pixel(255, 255, 0);
        queue_pixel(4095, 4095, 0);
        queue_pixel(256, 100, 2);
        queue_pixel(12'hAAA, 12'h555, 0);
        queue_pixel(12'h555, 12'hAAA, 0);

        // Smallest and largest scale, then a fractional one.
        queue_write(REG_NOISE_SCALE, 1);
        queue_pixel(4095, 4095, 0);
        queue_pixel(1, 3, 0);
        queue_write(REG_NOISE_SCALE, 16'hFFFF);
        queue_pixel(4095, 4095, 0);
        queue_pixel(2000, 77, 0);
        queue_write(REG_NOISE_SCALE, 16'h0180);
        queue_pixel(7, 13, 0);

        // Zero width and zero scale together: the dimension error wins.
        queue_write(REG_MAP_WIDTH, 0);
        queue_write(REG_NOISE_SCALE, 0);
        queue_pixel(0, 0, 0);

        // Width above the limit with high bits set, height at the limit, zero scale.
        queue_write(REG_MAP_WIDTH, 16'hFFFF);
        queue_write(REG_MAP_HEIGHT, MAX_DIMENSION);
        queue_pixel(5, 5, 0);

        // Saturated dimensions flag the final pixel.
        queue_write(REG_NOISE_SCALE, 16'h0040);
        queue_pixel(4095, 4095, 0);
        queue_pixel(4094, 4095, 0);

        // A write past the register list changes nothing.
        queue_write(REG_UNUSED, 16'hFFFF);
        queue_pixel(100, 200, 0);
        queue_write(REG_MAP_HEIGHT, 0);
        queue_pixel(1, 1, 0);

        // Random phases, each under its own register settings.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    w = 1;
                    h = 1;
                    s = 1;
                end
                1:
                begin
                    w = MAX_DIMENSION;
                    h = MAX_DIMENSION;
                    s = 16'hFFFF;
                end
                2:
                begin
                    w = 13'h1FFF;
                    h = $urandom_range(1, 64);
                    s = 16'd256;
                end
                default:
                begin
                    w = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 8191);
                    h = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 8191);
                    sel = $urandom_range(0, 11);
                    if (sel == 0)
                        s = 0;
                    else if (sel < 4)
                        s = $urandom_range(1, 255);
                    else if (sel < 7)
                        s = $urandom_range(256, 4096);
                    else
                        s = $urandom_range(1, 65535);
                end
            endcase
            queue_write(REG_MAP_WIDTH, {3'($urandom), w});
            queue_write(REG_MAP_HEIGHT, {3'($urandom), h});
            queue_write(REG_NOISE_SCALE, s);
            if ($urandom_range(0, 1))
                queue_write(REG_UNUSED, $urandom);

            wl = (w == 0 || w > MAX_DIMENSION) ? MAX_DIMENSION : w;
            hl = (h == 0 || h > MAX_DIMENSION) ? MAX_DIMENSION : h;
            bursty = 1'b0;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // Idle bursts come and go in stretches; the last phase runs flat out.
                if (n % 40 == 0)
                    bursty = (phase != PHASES - 1) && $urandom_range(0, 1);
                sel = $urandom_range(0, 9);
                if (sel == 0)
                    queue_pixel(wl - 1, hl - 1, pick_gap(bursty));
                else if (sel < 7)
                    queue_pixel($urandom_range(0, wl - 1), $urandom_range(0, hl - 1),
                                pick_gap(bursty));
                else
                    queue_pixel($urandom, $urandom, pick_gap(bursty));
            end
        end

        // Wait for every word to be taken and every result to come back.
        while (pending_items.size() != 0 || expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d result words over %0d register writes.",
                 words_checked, writes_made);
        $display("Among them %0d error-status words and %0d final-pixel flags.",
                 error_words, final_flags);
        if (mismatch_count == 0)
            $display("perlin_noise_2d_pixel_unit: match");
        else
            $display("perlin_noise_2d_pixel_unit: mismatch");
        $finish;
    end

endmodule
